[design/y4m_pkg.sv]
// shared types, constants and codes for the y4m luma extractor
package y4m_pkg;

    localparam int MAX_DIM_DEFAULT = 4096;
    localparam int DIM_W = 13;
    localparam int FRAME_W = 16;

    localparam logic [2:0] PH_MAGIC  = 3'd0;
    localparam logic [2:0] PH_HTAG   = 3'd1;
    localparam logic [2:0] PH_HVAL   = 3'd2;
    localparam logic [2:0] PH_FMAGIC = 3'd3;
    localparam logic [2:0] PH_FTAG   = 3'd4;
    localparam logic [2:0] PH_FVAL   = 3'd5;
    localparam logic [2:0] PH_PIX    = 3'd6;

    localparam logic [2:0] ERR_MAGIC     = 3'd0;
    localparam logic [2:0] ERR_HFIELD    = 3'd1;
    localparam logic [2:0] ERR_MISSDIM   = 3'd2;
    localparam logic [2:0] ERR_BADDIM    = 3'd3;
    localparam logic [2:0] ERR_CHROMA    = 3'd4;
    localparam logic [2:0] ERR_FMARK     = 3'd5;
    localparam logic [2:0] ERR_FFIELD    = 3'd6;
    localparam logic [2:0] ERR_TRUNC     = 3'd7;

    localparam logic [1:0] TAG_W     = 2'd0;
    localparam logic [1:0] TAG_H     = 2'd1;
    localparam logic [1:0] TAG_C     = 2'd2;
    localparam logic [1:0] TAG_OTHER = 2'd3;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_NL    = 8'h0a;

    // result item passed from front to back
    typedef struct packed {
        logic                 kind;
        logic [7:0]           luma;
        logic [FRAME_W-1:0]   frame_number;
        logic                 last_in_frame;
        logic [2:0]           error_code;
        logic [DIM_W-1:0]     frame_width;
        logic [DIM_W-1:0]     frame_height;
    } result_t;

    function automatic logic [7:0] magic_char(input logic [3:0] i);
        logic [7:0] c;
        case (i)
            4'd0: c = "Y";
            4'd1: c = "U";
            4'd2: c = "V";
            4'd3: c = "4";
            4'd4: c = "M";
            4'd5: c = "P";
            4'd6: c = "E";
            4'd7: c = "G";
            4'd8: c = "2";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] chroma_char(input logic [3:0] i);
        logic [7:0] c;
        case (i)
            4'd0: c = "4";
            4'd1: c = "2";
            4'd2: c = "0";
            4'd3: c = "j";
            4'd4: c = "p";
            4'd5: c = "e";
            4'd6: c = "g";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] frame_char(input logic [3:0] i);
        logic [7:0] c;
        case (i)
            4'd0: c = "F";
            4'd1: c = "R";
            4'd2: c = "A";
            4'd3: c = "M";
            4'd4: c = "E";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

[design/y4m_front.sv]
// byte classifier and parser state: turns stream bytes into result items
module y4m_front #(
    parameter int MAX_DIM = y4m_pkg::MAX_DIM_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [7:0]        data_byte,
    input  logic              start_of_file,
    input  logic              end_of_file,
    input  logic              take,
    output logic              res_valid,
    output y4m_pkg::result_t  res
);

    localparam int DW = y4m_pkg::DIM_W;

    logic [2:0]       phase_reg, phase_next;
    logic [3:0]       pos_reg, pos_next;
    logic [1:0]       tag_reg, tag_next;
    logic [DW-1:0]    wv_reg, wv_next, hv_reg, hv_next;
    logic             wseen_reg, wseen_next, hseen_reg, hseen_next;
    logic             cmis_reg, cmis_next;
    logic [DW-1:0]    col_reg, col_next, row_reg, row_next;
    logic [1:0]       plane_reg, plane_next;
    logic [15:0]      fc_reg, fc_next;
    logic             err_reg, err_next;

    // state as seen after an optional restart
    logic [2:0]       ph;
    logic [3:0]       pos;
    logic [1:0]       tg;
    logic [DW-1:0]    wv, hv, col, row;
    logic             wseen, hseen, cmis, errl;
    logic [1:0]       plane;
    logic [15:0]      fc;

    logic             err_hit, pix, last;
    logic [2:0]       ecode;
    logic [DW+3:0]    nv;
    logic [DW-1:0]    curv, pw, ph_h, wh, hh;
    logic             pw0, ph0;

    always_comb
    begin
        ph = phase_reg; pos = pos_reg; tg = tag_reg; wv = wv_reg; hv = hv_reg;
        wseen = wseen_reg; hseen = hseen_reg; cmis = cmis_reg; col = col_reg;
        row = row_reg; plane = plane_reg; fc = fc_reg; errl = err_reg;
        if (start_of_file)
        begin
            ph = y4m_pkg::PH_MAGIC; pos = '0; tg = '0; wv = '0; hv = '0;
            wseen = 1'b0; hseen = 1'b0; cmis = 1'b0; col = '0; row = '0;
            plane = '0; fc = '0; errl = 1'b0;
        end
    end

    always_comb
    begin
        phase_next = ph; pos_next = pos; tag_next = tg; wv_next = wv; hv_next = hv;
        wseen_next = wseen; hseen_next = hseen; cmis_next = cmis;
        col_next = col; row_next = row; plane_next = plane; fc_next = fc;
        err_next = errl;
        err_hit = 1'b0; ecode = y4m_pkg::ERR_MAGIC; pix = 1'b0; last = 1'b0;
        curv = (tg == y4m_pkg::TAG_W) ? wv : hv;
        nv = {4'd0, curv} * (DW+4)'(10) + (DW+4)'(data_byte - 8'h30);
        wh = {1'b0, wv[DW-1:1]};
        hh = {1'b0, hv[DW-1:1]};
        pw = (plane == 2'd0) ? wv : wh;
        ph_h = (plane == 2'd0) ? hv : hh;
        pw0 = (wh == '0); ph0 = (hh == '0);

        if (!errl)
        begin
            unique case (ph)
                y4m_pkg::PH_MAGIC:
                begin
                    if (pos < 4'd9)
                    begin
                        if (data_byte == y4m_pkg::magic_char(pos)) pos_next = pos + 4'd1;
                        else err_hit = 1'b1;
                    end
                    else if (data_byte == y4m_pkg::CH_SPACE)
                        phase_next = y4m_pkg::PH_HTAG;
                    else if (data_byte == y4m_pkg::CH_NL)
                    begin
                        if (!wseen || !hseen)
                        begin
                            err_hit = 1'b1; ecode = y4m_pkg::ERR_MISSDIM;
                        end
                        else if (wv == '0 || hv == '0)
                        begin
                            err_hit = 1'b1; ecode = y4m_pkg::ERR_BADDIM;
                        end
                        else if (cmis)
                        begin
                            err_hit = 1'b1; ecode = y4m_pkg::ERR_CHROMA;
                        end
                        else
                        begin
                            phase_next = y4m_pkg::PH_FMAGIC; pos_next = '0;
                            col_next = '0; row_next = '0; plane_next = '0;
                        end
                    end
                    else err_hit = 1'b1;
                end
                y4m_pkg::PH_HTAG:
                begin
                    phase_next = y4m_pkg::PH_HVAL;
                    case (data_byte) inside
                        "W": begin tag_next = y4m_pkg::TAG_W; wv_next = '0; wseen_next = 1'b1; end
                        "H": begin tag_next = y4m_pkg::TAG_H; hv_next = '0; hseen_next = 1'b1; end
                        "C": begin tag_next = y4m_pkg::TAG_C; cmis_next = 1'b0; pos_next = '0; end
                        "I", "F", "A", "X": tag_next = y4m_pkg::TAG_OTHER;
                        default:
                        begin
                            err_hit = 1'b1; ecode = y4m_pkg::ERR_HFIELD;
                        end
                    endcase
                end
                y4m_pkg::PH_HVAL:
                begin
                    if (data_byte == y4m_pkg::CH_SPACE || data_byte == y4m_pkg::CH_NL)
                    begin
                        logic cm;
                        cm = cmis;
                        if (tg == y4m_pkg::TAG_C && pos != 4'd7) cm = 1'b1;
                        cmis_next = cm;
                        if (data_byte == y4m_pkg::CH_SPACE) phase_next = y4m_pkg::PH_HTAG;
                        else if (!wseen || !hseen)
                        begin
                            err_hit = 1'b1; ecode = y4m_pkg::ERR_MISSDIM;
                        end
                        else if (wv == '0 || hv == '0)
                        begin
                            err_hit = 1'b1; ecode = y4m_pkg::ERR_BADDIM;
                        end
                        else if (cm)
                        begin
                            err_hit = 1'b1; ecode = y4m_pkg::ERR_CHROMA;
                        end
                        else
                        begin
                            phase_next = y4m_pkg::PH_FMAGIC; pos_next = '0;
                            col_next = '0; row_next = '0; plane_next = '0;
                        end
                    end
                    else if (tg == y4m_pkg::TAG_W || tg == y4m_pkg::TAG_H)
                    begin
                        if (data_byte < 8'h30 || data_byte > 8'h39 ||
                            nv > (DW+4)'(MAX_DIM))
                        begin
                            err_hit = 1'b1; ecode = y4m_pkg::ERR_BADDIM;
                        end
                        else if (tg == y4m_pkg::TAG_W) wv_next = nv[DW-1:0];
                        else hv_next = nv[DW-1:0];
                    end
                    else if (tg == y4m_pkg::TAG_C)
                    begin
                        if (pos < 4'd7 && data_byte == y4m_pkg::chroma_char(pos))
                            pos_next = pos + 4'd1;
                        else cmis_next = 1'b1;
                    end
                end
                y4m_pkg::PH_FMAGIC:
                begin
                    if (pos < 4'd5)
                    begin
                        if (data_byte == y4m_pkg::frame_char(pos)) pos_next = pos + 4'd1;
                        else
                        begin
                            err_hit = 1'b1; ecode = y4m_pkg::ERR_FMARK;
                        end
                    end
                    else if (data_byte == y4m_pkg::CH_SPACE) phase_next = y4m_pkg::PH_FTAG;
                    else if (data_byte == y4m_pkg::CH_NL) phase_next = y4m_pkg::PH_PIX;
                    else
                    begin
                        err_hit = 1'b1; ecode = y4m_pkg::ERR_FMARK;
                    end
                end
                y4m_pkg::PH_FTAG:
                begin
                    if (data_byte == "I" || data_byte == "X") phase_next = y4m_pkg::PH_FVAL;
                    else
                    begin
                        err_hit = 1'b1; ecode = y4m_pkg::ERR_FFIELD;
                    end
                end
                y4m_pkg::PH_FVAL:
                begin
                    if (data_byte == y4m_pkg::CH_SPACE) phase_next = y4m_pkg::PH_FTAG;
                    else if (data_byte == y4m_pkg::CH_NL) phase_next = y4m_pkg::PH_PIX;
                end
                default:
                begin
                    if (plane == 2'd0)
                    begin
                        pix = 1'b1;
                        last = (col + 1'b1 == wv) && (row + 1'b1 == hv);
                    end
                    col_next = col + 1'b1;
                    if (col + 1'b1 == pw)
                    begin
                        col_next = '0;
                        row_next = row + 1'b1;
                        if (row + 1'b1 == ph_h)
                        begin
                            row_next = '0;
                            // chroma planes are empty together or not at all
                            if (plane == 2'd2 || pw0 || ph0)
                            begin
                                plane_next = '0;
                                fc_next = fc + 16'd1;
                                phase_next = y4m_pkg::PH_FMAGIC;
                                pos_next = '0;
                            end
                            else plane_next = plane + 2'd1;
                        end
                    end
                end
            endcase
            if (!err_hit && end_of_file &&
                !(phase_next == y4m_pkg::PH_FMAGIC && pos_next == '0))
            begin
                err_hit = 1'b1; ecode = y4m_pkg::ERR_TRUNC;
            end
            if (err_hit) err_next = 1'b1;
        end
    end

    assign res_valid = !errl && (err_hit || pix);

    always_comb
    begin
        res.kind = err_hit;
        res.luma = err_hit ? 8'd0 : data_byte;
        res.frame_number = fc;
        res.last_in_frame = err_hit ? 1'b0 : last;
        res.error_code = err_hit ? ecode : 3'd0;
        res.frame_width = err_hit ? wv_next : wv;
        res.frame_height = err_hit ? hv_next : hv;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= y4m_pkg::PH_MAGIC; pos_reg <= '0; tag_reg <= '0;
            wv_reg <= '0; hv_reg <= '0; wseen_reg <= 1'b0; hseen_reg <= 1'b0;
            cmis_reg <= 1'b0; col_reg <= '0; row_reg <= '0; plane_reg <= '0;
            fc_reg <= '0; err_reg <= 1'b0;
        end
        else if (in_valid && take)
        begin
            phase_reg <= phase_next; pos_reg <= pos_next; tag_reg <= tag_next;
            wv_reg <= wv_next; hv_reg <= hv_next; wseen_reg <= wseen_next;
            hseen_reg <= hseen_next; cmis_reg <= cmis_next; col_reg <= col_next;
            row_reg <= row_next; plane_reg <= plane_next; fc_reg <= fc_next;
            err_reg <= err_next;
        end
    end

endmodule

[design/y4m_queue.sv]
// two-entry result queue between parser and output
module y4m_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  y4m_pkg::result_t  wr_data,
    output logic              full,
    output logic              out_valid,
    input  logic              out_stall,
    output y4m_pkg::result_t  out_data
);

    y4m_pkg::result_t mem_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       rp_reg, wp_reg;
    logic       rd_en;

    assign out_valid = cnt_reg != 2'd0;
    assign full = cnt_reg == 2'd2;
    assign rd_en = out_valid && !out_stall;
    assign out_data = mem_reg[rp_reg];

    always_comb
    begin
        cnt_next = cnt_reg + {1'b0, wr_en} - {1'b0, rd_en};
    end

    always_ff @(posedge clk)
    begin
        if (wr_en) mem_reg[wp_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0; rp_reg <= 1'b0; wp_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (wr_en) wp_reg <= !wp_reg;
            if (rd_en) rp_reg <= !rp_reg;
        end
    end

endmodule

[design/y4m_luma_extractor_top.sv]
// top level of the yuv4mpeg2 luma extractor
// One byte is accepted per cycle; each byte is parsed in the cycle it is taken and
// any result it makes enters a two-entry queue, so the block sustains one item per
// cycle and input stalls only when the queue is full. Width and height above MAX_DIM
// are rejected as bad dimensions.
module y4m_luma_extractor_top #(
    parameter int MAX_DIM = y4m_pkg::MAX_DIM_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        start_of_file,
    input  logic        end_of_file,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        kind,
    output logic [7:0]  luma,
    output logic [15:0] frame_number,
    output logic        last_in_frame,
    output logic [2:0]  error_code,
    output logic [12:0] frame_width,
    output logic [12:0] frame_height
);

    logic             full, res_valid;
    y4m_pkg::result_t res, q_out;

    assign in_stall = full;

    y4m_front #(.MAX_DIM(MAX_DIM)) u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .data_byte(data_byte),
        .start_of_file(start_of_file), .end_of_file(end_of_file),
        .take(!full), .res_valid(res_valid), .res(res)
    );

    y4m_queue u_queue (
        .clk(clk), .rst_n(rst_n), .wr_en(in_valid && !full && res_valid),
        .wr_data(res), .full(full), .out_valid(out_valid),
        .out_stall(out_stall), .out_data(q_out)
    );

    assign kind = q_out.kind;
    assign luma = q_out.luma;
    assign frame_number = q_out.frame_number;
    assign last_in_frame = q_out.last_in_frame;
    assign error_code = q_out.error_code;
    assign frame_width = q_out.frame_width;
    assign frame_height = q_out.frame_height;

    a_err_no_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind |-> !last_in_frame && luma == 8'd0)
        else $error("error item carries pixel data");
    a_luma_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !kind |-> error_code == 3'd0)
        else $error("luma item carries error code");
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with empty queue");

endmodule
